// ----- hw/rtl/ccl_pkg.sv -----
// shared constants and types of the connected component labeler
// no dependencies
package ccl_pkg;

  localparam int CCL_MAX_WIDTH  = 256;
  localparam int CCL_MAX_HEIGHT = 256;
  localparam int CCL_MAX_LABELS = 4095;
  localparam int CCL_LABEL_W    = 12;
  localparam int CCL_SIZE_W     = 9;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_CA,
    ST_CB,
    ST_RD,
    ST_RC,
    ST_OUT
  } ccl_state_t;

  typedef enum logic {
    PH_LOAD,
    PH_READ
  } ccl_phase_t;

endpackage

// ----- hw/rtl/ccl_if.sv -----
// valid/ready channels of the connected component labeler
// depends on ccl_pkg
interface ccl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] pixel;
  modport source (output valid, kind, pixel, input ready);
  modport sink (input valid, kind, pixel, output ready);
endinterface

interface ccl_out_if #(parameter int LABEL_W = ccl_pkg::CCL_LABEL_W);
  logic               valid;
  logic               ready;
  logic [7:0]         col;
  logic [7:0]         row;
  logic [LABEL_W-1:0] label;
  logic               is_start;
  logic               last;
  logic               overflow;
  modport source (output valid, col, row, label, is_start, last, overflow, input ready);
  modport sink (input valid, col, row, label, is_start, last, overflow, output ready);
endinterface

// ----- hw/rtl/connected_component_labeler.sv -----
// two-pass connected component labeler, 4-connectivity, top level
// depends on ccl_pkg and the channel interfaces in ccl_if.sv
//
// in_ch carries pixels (kind 0) in raster order while a frame loads and
// readout ticks (kind 1) afterwards; items of the other kind are dropped.
// out_ch gives one result per readout tick: position, root label,
// component start flag, last flag and the frame's overflow flag.
// a pixel is labelled in ST_UP; a pixel joining two labels then chases
// each root through the equivalence memory in ST_CA and ST_CB. a tick
// reads its label in ST_RD, chases its root in ST_RC when nonzero.
// the label memory and the equivalence memory each have one read port
// and one write port, and the single root chase unit sets the rate.
// after the last pixel the block turns to readout; after the last result
// a new frame starts. an apb write of frame_width or frame_height also
// restarts the frame. reset restores 256 x 256 and an empty frame.
// a stalled receiver holds the result register; one further item may be
// taken meanwhile and waits finished until the register frees.
module connected_component_labeler #(
  parameter int MAX_WIDTH  = ccl_pkg::CCL_MAX_WIDTH,
  parameter int MAX_HEIGHT = ccl_pkg::CCL_MAX_HEIGHT,
  parameter int MAX_LABELS = ccl_pkg::CCL_MAX_LABELS
) (
  input  logic        clk,
  input  logic        rst_n,
  ccl_in_if.sink      in_ch,
  ccl_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ccl_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int PW    = $clog2(DEPTH);
  localparam int TW    = PW + 1;
  localparam int LW    = $clog2(MAX_LABELS + 1);
  localparam int NLW   = $clog2(MAX_LABELS + 2);
  localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  logic [LW:0]   ls_mem [0:DEPTH-1];
  logic [LW-1:0] eq_mem [0:MAX_LABELS];

  ccl_state_t state_r, state_nxt;
  ccl_phase_t phase_r, phase_nxt;
  logic [WW-1:0]  w_r, w_nxt;
  logic [HW-1:0]  h_r, h_nxt;
  logic [TW-1:0]  total_r;
  logic [PW-1:0]  pos_r, pos_nxt, rpos_r, rpos_nxt;
  logic [CW-1:0]  col_r, col_nxt, rcol_r, rcol_nxt;
  logic [RW-1:0]  row_r, row_nxt, rrow_r, rrow_nxt;
  logic [NLW-1:0] next_r, next_nxt;
  logic           ovf_r, ovf_nxt;

  logic           fg_r, fg_nxt;
  logic [LW-1:0]  left_r, left_nxt, x_r, x_nxt, b_r, b_nxt, ra_r, ra_nxt;
  logic [LW-1:0]  lab_r, lab_nxt, root_r, root_nxt;
  logic           fresh_r, fresh_nxt;

  logic           ov_r;
  logic [7:0]     ocol_r, orow_r;
  logic [LW-1:0]  olab_r;
  logic           ostart_r, olast_r, oovf_r;
  logic           out_load;

  logic           ls_we, ls_re, eq_we, eq_re;
  logic [PW-1:0]  ls_waddr, ls_raddr;
  logic [LW:0]    ls_wdata, ls_q;
  logic [LW-1:0]  eq_waddr, eq_wdata, eq_raddr, eq_q;

  logic           cfg_we;
  logic [LW-1:0]  up_lab, left_lab, lab;
  logic           fresh, stop, last_rd, load_last;

  function automatic logic [WW-1:0] clamp_w(input logic [8:0] v);
    if (v == 9'd0) return WW'(1);
    if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [8:0] v);
    if (v == 9'd0) return HW'(1);
    if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
    return HW'(v);
  endfunction

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(h_r) : 32'(w_r);
  assign cfg_we = psel && penable && pwrite;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = ov_r;
  assign out_ch.col      = ocol_r;
  assign out_ch.row      = orow_r;
  assign out_ch.label    = olab_r;
  assign out_ch.is_start = ostart_r;
  assign out_ch.last     = olast_r;
  assign out_ch.overflow = oovf_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    pos_nxt   = pos_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    rpos_nxt  = rpos_r;
    rcol_nxt  = rcol_r;
    rrow_nxt  = rrow_r;
    next_nxt  = next_r;
    ovf_nxt   = ovf_r;
    fg_nxt    = fg_r;
    left_nxt  = left_r;
    x_nxt     = x_r;
    b_nxt     = b_r;
    ra_nxt    = ra_r;
    lab_nxt   = lab_r;
    root_nxt  = root_r;
    fresh_nxt = fresh_r;
    out_load  = 1'b0;
    ls_we     = 1'b0;
    ls_waddr  = pos_r;
    ls_wdata  = '0;
    ls_re     = 1'b0;
    ls_raddr  = pos_r - PW'(w_r);
    eq_we     = 1'b0;
    eq_waddr  = '0;
    eq_wdata  = '0;
    eq_re     = 1'b0;
    eq_raddr  = x_r;
    lab       = '0;
    fresh     = 1'b0;

    up_lab    = (row_r != '0) ? ls_q[LW-1:0] : '0;
    left_lab  = (col_r != '0) ? left_r : '0;
    stop      = (eq_q == '0) || (eq_q >= x_r);
    last_rd   = (TW'(rpos_r) + TW'(1) == total_r);
    load_last = (TW'(pos_r) + TW'(1) == total_r);

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (phase_r == PH_LOAD && in_ch.kind == KIND_PIXEL) begin
            fg_nxt    = (in_ch.pixel != 8'd0);
            ls_re     = 1'b1;
            state_nxt = ST_UP;
          end else if (phase_r == PH_READ && in_ch.kind == KIND_TICK) begin
            ls_re     = 1'b1;
            ls_raddr  = rpos_r;
            state_nxt = ST_RD;
          end
        end
      end
      ST_UP: begin
        state_nxt = ST_IDLE;
        if (fg_r) begin
          if (left_lab == '0 && up_lab == '0) begin
            if (next_r > NLW'(MAX_LABELS)) begin
              ovf_nxt = 1'b1;
            end else begin
              lab      = LW'(next_r);
              fresh    = 1'b1;
              eq_we    = 1'b1;
              eq_waddr = LW'(next_r);
              eq_wdata = LW'(next_r);
              next_nxt = next_r + NLW'(1);
            end
          end else if (left_lab != '0 && up_lab != '0) begin
            lab = (left_lab < up_lab) ? left_lab : up_lab;
            if (left_lab != up_lab) begin
              x_nxt     = left_lab;
              b_nxt     = up_lab;
              eq_re     = 1'b1;
              eq_raddr  = left_lab;
              state_nxt = ST_CA;
            end
          end else begin
            lab = left_lab | up_lab;
          end
        end
        ls_we    = 1'b1;
        ls_wdata = {fresh, lab};
        left_nxt = lab;
        if (load_last) begin
          phase_nxt = PH_READ;
          rpos_nxt  = '0;
          rcol_nxt  = '0;
          rrow_nxt  = '0;
        end else begin
          pos_nxt = pos_r + PW'(1);
          if (WW'(col_r) + WW'(1) == w_r) begin
            col_nxt = '0;
            row_nxt = row_r + RW'(1);
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
      end
      ST_CA: begin
        eq_re = 1'b1;
        if (stop) begin
          ra_nxt    = x_r;
          x_nxt     = b_r;
          eq_raddr  = b_r;
          state_nxt = ST_CB;
        end else begin
          x_nxt    = eq_q;
          eq_raddr = eq_q;
        end
      end
      ST_CB: begin
        if (stop) begin
          if (ra_r != x_r) begin
            eq_we    = 1'b1;
            eq_waddr = (ra_r < x_r) ? x_r : ra_r;
            eq_wdata = (ra_r < x_r) ? ra_r : x_r;
          end
          state_nxt = ST_IDLE;
        end else begin
          eq_re    = 1'b1;
          x_nxt    = eq_q;
          eq_raddr = eq_q;
        end
      end
      ST_RD: begin
        lab_nxt   = ls_q[LW-1:0];
        fresh_nxt = ls_q[LW];
        if (ls_q[LW-1:0] == '0) begin
          root_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          x_nxt     = ls_q[LW-1:0];
          eq_re     = 1'b1;
          eq_raddr  = ls_q[LW-1:0];
          state_nxt = ST_RC;
        end
      end
      ST_RC: begin
        if (stop) begin
          root_nxt  = x_r;
          state_nxt = ST_OUT;
        end else begin
          eq_re    = 1'b1;
          x_nxt    = eq_q;
          eq_raddr = eq_q;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (last_rd) begin
            phase_nxt = PH_LOAD;
            pos_nxt   = '0;
            col_nxt   = '0;
            row_nxt   = '0;
            rpos_nxt  = '0;
            next_nxt  = NLW'(1);
            ovf_nxt   = 1'b0;
          end else begin
            rpos_nxt = rpos_r + PW'(1);
            if (WW'(rcol_r) + WW'(1) == w_r) begin
              rcol_nxt = '0;
              rrow_nxt = rrow_r + RW'(1);
            end else begin
              rcol_nxt = rcol_r + CW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (paddr[2] == REG_FRAME_WIDTH) begin
        w_nxt = clamp_w(pwdata[8:0]);
      end else begin
        h_nxt = clamp_h(pwdata[8:0]);
      end
      phase_nxt = PH_LOAD;
      pos_nxt   = '0;
      col_nxt   = '0;
      row_nxt   = '0;
      rpos_nxt  = '0;
      rcol_nxt  = '0;
      rrow_nxt  = '0;
      next_nxt  = NLW'(1);
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_LOAD;
      w_r     <= WW'(W_RST);
      h_r     <= HW'(H_RST);
      pos_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      rpos_r  <= '0;
      rcol_r  <= '0;
      rrow_r  <= '0;
      next_r  <= NLW'(1);
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      pos_r   <= pos_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      rpos_r  <= rpos_nxt;
      rcol_r  <= rcol_nxt;
      rrow_r  <= rrow_nxt;
      next_r  <= next_nxt;
      ovf_r   <= ovf_nxt;
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r <= TW'(w_r) * TW'(h_r);
    fg_r    <= fg_nxt;
    left_r  <= left_nxt;
    x_r     <= x_nxt;
    b_r     <= b_nxt;
    ra_r    <= ra_nxt;
    lab_r   <= lab_nxt;
    root_r  <= root_nxt;
    fresh_r <= fresh_nxt;
    if (out_load) begin
      ocol_r   <= 8'(rcol_r);
      orow_r   <= 8'(rrow_r);
      olab_r   <= root_r;
      ostart_r <= fresh_r && (root_r == lab_r) && (root_r != '0);
      olast_r  <= last_rd;
      oovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[ls_waddr] <= ls_wdata;
    end
    if (ls_re) begin
      ls_q <= ls_mem[ls_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (eq_we) begin
      eq_mem[eq_waddr] <= eq_wdata;
    end
    if (eq_re) begin
      eq_q <= eq_mem[eq_raddr];
    end
  end

  a_eq_toward_root: assert property (@(posedge clk) disable iff (!rst_n)
    eq_we |-> eq_wdata <= eq_waddr)
    else $error("equivalence entry points above itself");

  a_store_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    ls_we |-> phase_r == PH_LOAD)
    else $error("label store written during readout");

  a_start_fg: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ostart_r) |-> olab_r != '0)
    else $error("start flag on background");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_rd && !cfg_we) |=> (phase_r == PH_LOAD && pos_r == '0))
    else $error("frame did not restart after last result");

endmodule
